// ===== design/double_ended_queue_with_search_assert.svh =====
// Assertion macros shared by the deque checker.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define DEQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque assertion failed");

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque assertion failed");

`endif

// ===== design/deq_pkg.sv =====
// Shared types and constants of the deque with search.
package deq_pkg;

	localparam int DATA_W = 32;
	localparam int FUNC_W = 3;
	localparam int POS_W  = 4;
	localparam int CNT_W  = 5;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_FRONT = 3'd0,
		FN_PUSH_BACK  = 3'd1,
		FN_POP_FRONT  = 3'd2,
		FN_POP_BACK   = 3'd3,
		FN_FIND       = 3'd4,
		FN_CLEAR      = 3'd5
	} func_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_FIND = 3'b100
	} state_t;

endpackage

// ===== design/deq_ram.sv =====
// Entry memory of the deque: one write port, one read port with registered data.
module deq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read, so a stalled result keeps its value.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/double_ended_queue_with_search.sv =====
// Bounded deque of signed 32-bit values held in a ring in one memory. Each transaction on the
// input channel carries one operation (push front, push back, pop front, pop back, find, clear)
// and yields exactly one result transaction. Pushes, pops, clear and unused codes pass through the
// execute state, which loads the result once the output register is free. Find walks the ring from
// the front one entry per cycle through the memory's single read port and stops at the first match
// or after the last entry; an empty store reports a miss without a walk. A new transaction is
// accepted as soon as the previous one has been loaded into the output register, even while that
// result still waits for out_ready.
module double_ended_queue_with_search #(
	parameter int CAPACITY = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [deq_pkg::FUNC_W-1:0]           func,
	input  logic signed [deq_pkg::DATA_W-1:0]    operand_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 ok,
	output logic signed [deq_pkg::DATA_W-1:0]    popped_value,
	output logic                                 found,
	output logic [deq_pkg::POS_W-1:0]            found_position,
	output logic                                 is_empty,
	output logic [deq_pkg::CNT_W-1:0]            entry_count
);

	import deq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [AW:0]   CAP_A     = (AW+1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
	localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

	state_t            state_q, state_d;
	func_t             func_q;
	logic [DATA_W-1:0] operand_q;
	logic [AW-1:0]     front_q, front_d;
	logic [CW-1:0]     count_q, count_d;
	logic [AW-1:0]     idx_q, idx_d;

	logic              out_valid_q;
	logic              ok_q, found_q, empty_q;
	logic [DATA_W-1:0] pop_q;
	logic [POS_W-1:0]  pos_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              rd_en, wr_en;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic [DATA_W-1:0] rd_data;

	logic              finish, res_ok, res_found;
	logic [DATA_W-1:0] res_pop;
	logic [AW-1:0]     res_pos;
	logic              out_free, full, empty, hit, last;
	logic [AW-1:0]     front_dec;

	function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
		input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= CAP_A) begin
			sum = sum - CAP_A;
		end
		return sum[AW-1:0];
	endfunction

	deq_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(DATA_W)
	) u_deq_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(operand_q),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign full      = (count_q == CAP_C);
	assign empty     = (count_q == '0);
	assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - AW'(1);
	assign hit       = !empty && (rd_data == operand_q);
	assign last      = empty || (CW'(idx_q) == count_q - CW'(1));

	// Writes happen only in the execute state and reads only on acceptance or while
	// searching, so the memory never sees a read and a write in the same cycle.
	always_comb begin
		state_d   = state_q;
		front_d   = front_q;
		count_d   = count_q;
		idx_d     = idx_q;
		rd_en     = 1'b0;
		rd_addr   = front_q;
		wr_en     = 1'b0;
		wr_addr   = front_q;
		finish    = 1'b0;
		res_ok    = 1'b0;
		res_found = 1'b0;
		res_pop   = '0;
		res_pos   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					rd_en = 1'b1;
					if (func == FN_POP_BACK) begin
						rd_addr = ring_addr(front_q, AW'(count_q - CW'(1)));
					end
					idx_d   = '0;
					state_d = (func == FN_FIND) ? S_FIND : S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					finish  = 1'b1;
					state_d = S_IDLE;
					unique case (func_q)
						FN_PUSH_FRONT: begin
							if (!full) begin
								wr_en   = 1'b1;
								wr_addr = front_dec;
								front_d = front_dec;
								count_d = count_q + CW'(1);
								res_ok  = 1'b1;
							end
						end
						FN_PUSH_BACK: begin
							if (!full) begin
								wr_en   = 1'b1;
								wr_addr = ring_addr(front_q, AW'(count_q));
								count_d = count_q + CW'(1);
								res_ok  = 1'b1;
							end
						end
						FN_POP_FRONT: begin
							if (!empty) begin
								res_pop = rd_data;
								front_d = ring_addr(front_q, AW'(1));
								count_d = count_q - CW'(1);
								res_ok  = 1'b1;
							end
						end
						FN_POP_BACK: begin
							if (!empty) begin
								res_pop = rd_data;
								count_d = count_q - CW'(1);
								res_ok  = 1'b1;
							end
						end
						FN_CLEAR: begin
							front_d = '0;
							count_d = '0;
							res_ok  = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			S_FIND: begin
				if (hit || last) begin
					if (out_free) begin
						finish    = 1'b1;
						res_ok    = 1'b1;
						res_found = hit;
						res_pos   = hit ? idx_q : '0;
						state_d   = S_IDLE;
					end
				end else begin
					rd_en   = 1'b1;
					rd_addr = ring_addr(front_q, idx_q + AW'(1));
					idx_d   = idx_q + AW'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q    <= func_t'(func);
			operand_q <= operand_value;
		end
		if (finish) begin
			ok_q    <= res_ok;
			pop_q   <= res_pop;
			found_q <= res_found;
			pos_q   <= POS_W'(res_pos);
			empty_q <= (count_d == '0);
			cnt_q   <= CNT_W'(count_d);
		end
	end

	assign out_valid      = out_valid_q;
	assign ok             = ok_q;
	assign popped_value   = pop_q;
	assign found          = found_q;
	assign found_position = pos_q;
	assign is_empty       = empty_q;
	assign entry_count    = cnt_q;

endmodule

// ===== design/deq_checker.sv =====
// Port-level checker for the deque with search, bound to the top level.
`include "double_ended_queue_with_search_assert.svh"

module deq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              ok,
	input logic signed [deq_pkg::DATA_W-1:0] popped_value,
	input logic                              found,
	input logic [deq_pkg::POS_W-1:0]         found_position,
	input logic                              is_empty,
	input logic [deq_pkg::CNT_W-1:0]         entry_count
);

	// A stalled result must stay valid and must not change under the consumer.
	`DEQ_ASSERT_NEXT(a_out_keep, out_valid && !out_ready, out_valid)
	`DEQ_ASSERT_NEXT(a_out_data, out_valid && !out_ready, $stable({ok, popped_value, entry_count}))

	// The block works on one transaction at a time.
	`DEQ_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

	// A failed operation never reports a popped value or a match.
	`DEQ_ASSERT_NOW(a_fail_clean, out_valid && !ok, popped_value == 0 && !found)

	// A match needs a non-empty store; without one the position reads zero.
	`DEQ_ASSERT_NOW(a_found_pos, out_valid, found ? !is_empty : found_position == 0)

endmodule

bind double_ended_queue_with_search deq_checker u_deq_checker (.*);
